### rtl/lcdtr_pkg.sv
package lcdtr_pkg;

   // Display geometry
   localparam int PAGE_COUNT   = 4;
   localparam int COLUMN_COUNT = 128;

   localparam int GLYPH_COLS  = 5;
   localparam int CHAR_ADV    = 6;
   localparam int FONT_DEPTH  = 64;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam int FONT_W      = 8 * GLYPH_COLS;

   // Request modes
   localparam logic [1:0] MODE_SET_POS = 2'd0;
   localparam logic [1:0] MODE_CHAR    = 2'd1;
   localparam logic [1:0] MODE_INIT    = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // Controller commands
   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] GLYPH_LO   = 8'h20;
   localparam logic [7:0] GLYPH_HI   = 8'h5F;
   localparam logic [7:0] LOWER_LO   = 8'h61;
   localparam logic [7:0] LOWER_HI   = 8'h7A;
   localparam logic [7:0] CASE_FOLD  = 8'h20;

   localparam logic [7:0] INIT_SEQ [8] = '{
      8'hAE, 8'hA2, 8'hA0, 8'hC8, 8'h22, 8'h2F, 8'h40, 8'hAF
   };

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] page_in;
      logic [6:0] column_in;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

   // 5x7 font, column 0 in the top byte
   localparam logic [FONT_W-1:0] FONT [FONT_DEPTH] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
      40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
      40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
      40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
      40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
      40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040
   };

endpackage

### rtl/lcd_text_renderer_core.sv
// Channel   Dir  Fields                                   Handshake
// req_      in   mode, page_in, column_in, char_code      req_valid / req_ready
// rsp_      out  out_byte, is_data, last                  rsp_valid / rsp_ready
//
// One output byte per cycle: set position gives 3, init 8, a character 6,
// or 9 when it wraps. The single byte sequencer sets the rate; the next item
// is taken in the cycle its predecessor's last byte enters the output register.
// Synchronous active-high reset clears the cursor (page 0, column 0) and
// all valid flags. A stalled rsp_ready holds the output register and the
// sequencer; mode 3 items are taken and produce nothing.
module lcd_text_renderer_core #(
   parameter int PAGE_COUNT   = lcdtr_pkg::PAGE_COUNT,
   parameter int COLUMN_COUNT = lcdtr_pkg::COLUMN_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lcdtr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lcdtr_pkg::rsp_type rsp_data
);

   localparam logic [7:0] WRAP_LIMIT = 8'(COLUMN_COUNT - 6);
   localparam logic [3:0] PAGE_MOD   = 4'(PAGE_COUNT);

   // Sequencer steps: 0..2 cursor commands, 3..7 glyph columns, 8 blank.
   // Init runs 0..7 through the init table.
   localparam logic [3:0] STEP_GLYPH = 4'd3;
   localparam logic [3:0] STEP_BLANK = 4'd8;
   localparam logic [3:0] STEP_CURS  = 4'd2;
   localparam logic [3:0] STEP_INIT  = 4'd7;

   // cursor state
   logic [1:0] cur_page_ff, cur_page_in;
   logic [7:0] cur_col_ff,  cur_col_in;

   // job in progress
   logic       job_valid_ff, job_valid_in;
   logic [1:0] job_mode_ff,  job_mode_in;
   logic [1:0] job_page_ff,  job_page_in;
   logic [7:0] job_col_ff,   job_col_in;
   logic [3:0] step_ff,      step_in;
   logic [3:0] last_step_ff, last_step_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   lcdtr_pkg::rsp_type  rsp_data_ff,  rsp_data_in;

   logic                             accept;
   logic                             out_adv;
   logic                             emit;
   logic                             job_final;
   logic                             wrap;
   logic [3:0]                       page_nx;
   logic [7:0]                       ch;
   logic [lcdtr_pkg::FONT_AW-1:0]    glyph_idx;
   logic                             rom_rd;
   logic [lcdtr_pkg::FONT_W-1:0]     glyph_q;
   logic [7:0]                       byte_sel;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign job_final = step_ff == last_step_ff;
   assign emit      = job_valid_ff && out_adv;
   assign req_ready = !job_valid_ff || (out_adv && job_final);
   assign accept    = req_valid && req_ready;

   // Character folding and font index
   always_comb begin
      ch = req_data.char_code;
      if (ch >= lcdtr_pkg::LOWER_LO && ch <= lcdtr_pkg::LOWER_HI) begin
         ch = ch - lcdtr_pkg::CASE_FOLD;
      end
      if (ch < lcdtr_pkg::GLYPH_LO || ch > lcdtr_pkg::GLYPH_HI) begin
         ch = lcdtr_pkg::GLYPH_LO;
      end
      glyph_idx = lcdtr_pkg::FONT_AW'(ch - lcdtr_pkg::GLYPH_LO);
   end

   assign rom_rd = accept && req_data.mode == lcdtr_pkg::MODE_CHAR;

   lcdtr_font_rom u_font (
      .clock      (clock),
      .rd_en      (rom_rd),
      .rd_addr    (glyph_idx),
      .rd_data_ff (glyph_q)
   );

   // Next page on wrap: (page + 1) mod PAGE_COUNT by repeated subtraction,
   // the sum never exceeds 4.
   always_comb begin
      page_nx = {2'b00, cur_page_ff} + 4'd1;
      for (int i = 0; i < 4; i++) begin
         if (page_nx >= PAGE_MOD) begin
            page_nx = page_nx - PAGE_MOD;
         end
      end
   end

   assign wrap = cur_col_ff > WRAP_LIMIT;

   // Step advance on emit, cursor update and job load at accept
   always_comb begin
      cur_page_in  = cur_page_ff;
      cur_col_in   = cur_col_ff;
      job_mode_in  = job_mode_ff;
      job_page_in  = job_page_ff;
      job_col_in   = job_col_ff;
      step_in      = step_ff;
      last_step_in = last_step_ff;
      job_valid_in = job_valid_ff;

      if (emit) begin
         step_in = step_ff + 4'd1;
         if (job_final) begin
            job_valid_in = 1'b0;
         end
      end

      if (accept) begin
         job_mode_in = req_data.mode;
         unique case (req_data.mode)
            lcdtr_pkg::MODE_SET_POS: begin
               cur_page_in  = req_data.page_in;
               cur_col_in   = {1'b0, req_data.column_in};
               job_page_in  = req_data.page_in;
               job_col_in   = {1'b0, req_data.column_in};
               step_in      = '0;
               last_step_in = STEP_CURS;
               job_valid_in = 1'b1;
            end
            lcdtr_pkg::MODE_CHAR: begin
               if (wrap) begin
                  cur_page_in = page_nx[1:0];
                  job_page_in = page_nx[1:0];
                  job_col_in  = '0;
                  cur_col_in  = 8'(lcdtr_pkg::CHAR_ADV);
                  step_in     = '0;
               end else begin
                  cur_col_in  = cur_col_ff + 8'(lcdtr_pkg::CHAR_ADV);
                  step_in     = STEP_GLYPH;
               end
               last_step_in = STEP_BLANK;
               job_valid_in = 1'b1;
            end
            lcdtr_pkg::MODE_INIT: begin
               step_in      = '0;
               last_step_in = STEP_INIT;
               job_valid_in = 1'b1;
            end
            default: begin
               // unused mode: taken and dropped
            end
         endcase
      end
   end

   // Byte for the current step
   always_comb begin
      case (step_ff)
         4'd0:    byte_sel = lcdtr_pkg::CMD_PAGE | {6'b0, job_page_ff};
         4'd1:    byte_sel = lcdtr_pkg::CMD_COL_HI | {4'b0, job_col_ff[7:4]};
         4'd2:    byte_sel = {4'b0, job_col_ff[3:0]};
         4'd3:    byte_sel = glyph_q[39:32];
         4'd4:    byte_sel = glyph_q[31:24];
         4'd5:    byte_sel = glyph_q[23:16];
         4'd6:    byte_sel = glyph_q[15:8];
         4'd7:    byte_sel = glyph_q[7:0];
         default: byte_sel = '0;
      endcase
      if (job_mode_ff == lcdtr_pkg::MODE_INIT) begin
         byte_sel = lcdtr_pkg::INIT_SEQ[step_ff[2:0]];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_adv) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_data_in.out_byte = byte_sel;
         rsp_data_in.is_data  = job_mode_ff == lcdtr_pkg::MODE_CHAR && step_ff >= STEP_GLYPH;
         rsp_data_in.last     = job_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_page_ff  <= '0;
         cur_col_ff   <= '0;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         last_step_ff <= '0;
         job_mode_ff  <= lcdtr_pkg::MODE_NONE;
      end else begin
         cur_page_ff  <= cur_page_in;
         cur_col_ff   <= cur_col_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         last_step_ff <= last_step_in;
         job_mode_ff  <= job_mode_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      job_page_ff <= job_page_in;
      job_col_ff  <= job_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/lcdtr_font_rom.sv
module lcdtr_font_rom (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [lcdtr_pkg::FONT_AW-1:0]      rd_addr,
   output logic [lcdtr_pkg::FONT_W-1:0]       rd_data_ff
);

   logic [lcdtr_pkg::FONT_W-1:0] rom [lcdtr_pkg::FONT_DEPTH];

   assign rom = lcdtr_pkg::FONT;

   // synchronous read, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_addr];
      end
   end

endmodule
